/* hdl/assert_macros.svh */
// Assertion macros shared by the thermostat RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define MHT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mht check failed");

// Check that a condition holds in the cycle after its trigger
`define MHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mht check failed");

`endif

/* hdl/mht_pkg.sv */
// Types and constants of the multimode hysteresis thermostat
package mht_pkg;

    localparam int unsigned MODE_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned TGT_W = 8;
    localparam int unsigned DELAY_W = 8;
    localparam int unsigned BAND_W = 3;
    localparam int unsigned STAGE_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_ON      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_DELAY  = 3'd4;

    localparam logic [TGT_W-1:0]   TARGET_FLOOR = 8'd16;
    localparam logic [TGT_W-1:0]   TARGET_RESET = 8'd24;
    localparam logic [DELAY_W-1:0] DELAY_RESET  = 8'd1;

    localparam logic [BAND_W-1:0] BAND_DAY        = 3'd2;
    localparam logic [BAND_W-1:0] BAND_NIGHT      = 3'd5;
    localparam logic [BAND_W-1:0] BAND_NIGHT_AUTO = 3'd3;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOP   = 3'd0,
        MODE_HEAT   = 3'd1,
        MODE_COOL   = 3'd2,
        MODE_AUTO   = 3'd3,
        MODE_STAGED = 3'd4
    } mode_t;

    typedef enum logic [STAGE_W-1:0] {
        STAGE_CLOSED  = 2'd0,
        STAGE_WAITING = 2'd1,
        STAGE_OPEN    = 2'd2
    } stage_t;

endpackage

/* hdl/mht_if.sv */
// Handshake channels of the thermostat: temperature in, relay result out
interface mht_in_if #(
    parameter int unsigned TEMP_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic [TEMP_BITS-1:0] temperature;

    modport source (output valid, output temperature, input ready);
    modport sink (input valid, input temperature, output ready);
endinterface

interface mht_out_if;
    logic       valid;
    logic       ready;
    logic       heat_relay;
    logic       cool_relay;
    logic       boost_relay;
    logic       fan_relay;
    logic [1:0] stage;

    modport source (
        output valid, output heat_relay, output cool_relay, output boost_relay,
        output fan_relay, output stage, input ready
    );
    modport sink (
        input valid, input heat_relay, input cool_relay, input boost_relay,
        input fan_relay, input stage, output ready
    );
endinterface

/* hdl/multimode_hysteresis_thermostat_unit.sv */
// Multimode hysteresis thermostat: relay control with staged heating
// Path: accepted temperature beat -> input register -> relay state (result) registers.
// Throughput: one beat per cycle while result_out.ready is not held low; input register
//   feeds one compare-and-update stage whose relay state registers form the result register.
// Reset: relays off, stage closed, mode stop, target 24, delay 1, fan off.
`include "assert_macros.svh"

module multimode_hysteresis_thermostat_unit #(
    parameter int unsigned TEMP_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [mht_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mht_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    mht_in_if.sink                          temp_in,
    mht_out_if.source                       result_out
);
    import mht_pkg::*;

    localparam int unsigned CW = ((TEMP_BITS > TGT_W + 1) ? TEMP_BITS : TGT_W + 1) + 1;

    mode_t                run_mode_reg;
    logic                 night_mode_reg;
    logic [TGT_W-1:0]     target_reg;
    logic                 fan_on_reg;
    logic [DELAY_W-1:0]   sync_delay_reg;

    logic                 s1_valid_reg;
    logic [TEMP_BITS-1:0] temp_s1_reg;
    logic                 out_valid_reg;
    logic                 s1_advance;

    logic                 heat_on_reg, heat_on_next;
    logic                 cool_on_reg, cool_on_next;
    logic                 boost_on_reg, boost_on_next;
    stage_t               stage_reg, stage_next;
    logic [DELAY_W-1:0]   delay_count_reg, delay_count_next;
    logic                 delay_active_reg, delay_active_next;
    logic                 fan_out_reg;

    logic [CW-1:0]        t_ext;
    logic [CW-1:0]        tgt_ext;
    logic [CW-1:0]        lo_thr;
    logic [CW-1:0]        hi_thr;
    logic [BAND_W-1:0]    band;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg   <= MODE_STOP;
            night_mode_reg <= 1'b0;
            target_reg     <= TARGET_RESET;
            fan_on_reg     <= 1'b0;
            sync_delay_reg <= DELAY_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_RUN_MODE:    run_mode_reg   <= mode_t'(cfg_wdata[MODE_W-1:0]);
                CFG_NIGHT_MODE:  night_mode_reg <= cfg_wdata[0];
                CFG_TARGET_TEMP: target_reg     <= (cfg_wdata < TARGET_FLOOR) ?
                                                   TARGET_FLOOR : cfg_wdata;
                CFG_FAN_ON:      fan_on_reg     <= cfg_wdata[0];
                CFG_SYNC_DELAY:  sync_delay_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // handshake: advance stage 1 when the result register is free or drained
    assign s1_advance    = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign temp_in.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (temp_in.ready)
            begin
                s1_valid_reg <= temp_in.valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (temp_in.valid && temp_in.ready)
        begin
            temp_s1_reg <= temp_in.temperature;
        end
    end

    // thresholds
    assign t_ext   = CW'(temp_s1_reg);
    assign tgt_ext = CW'(target_reg);
    assign band    = !night_mode_reg ? BAND_DAY :
                     (run_mode_reg == MODE_AUTO) ? BAND_NIGHT_AUTO : BAND_NIGHT;
    assign lo_thr  = tgt_ext - CW'(band);
    assign hi_thr  = tgt_ext + CW'(band);

    always_comb
    begin
        heat_on_next      = heat_on_reg;
        cool_on_next      = cool_on_reg;
        boost_on_next     = boost_on_reg;
        stage_next        = stage_reg;
        delay_count_next  = delay_count_reg;
        delay_active_next = delay_active_reg;

        if (run_mode_reg != MODE_STAGED)
        begin
            boost_on_next     = 1'b0;
            stage_next        = STAGE_CLOSED;
            delay_count_next  = '0;
            delay_active_next = 1'b0;
        end

        unique case (run_mode_reg)
            MODE_HEAT:
            begin
                if (t_ext <= lo_thr)
                begin
                    heat_on_next = 1'b1;
                    cool_on_next = 1'b0;
                end
                else if (t_ext > tgt_ext)
                begin
                    heat_on_next = 1'b0;
                    cool_on_next = 1'b0;
                end
            end
            MODE_COOL:
            begin
                if (t_ext >= hi_thr)
                begin
                    cool_on_next = 1'b1;
                    heat_on_next = 1'b0;
                end
                else if (t_ext < tgt_ext)
                begin
                    heat_on_next = 1'b0;
                    cool_on_next = 1'b0;
                end
            end
            MODE_AUTO:
            begin
                if (t_ext <= lo_thr)
                begin
                    heat_on_next = 1'b1;
                    cool_on_next = 1'b0;
                end
                else if (t_ext >= hi_thr)
                begin
                    cool_on_next = 1'b1;
                    heat_on_next = 1'b0;
                end
                else if (t_ext == tgt_ext)
                begin
                    heat_on_next = 1'b0;
                    cool_on_next = 1'b0;
                end
            end
            MODE_STAGED:
            begin
                cool_on_next = 1'b0;
                if (t_ext <= lo_thr)
                begin
                    if (stage_reg == STAGE_CLOSED)
                    begin
                        stage_next        = STAGE_WAITING;
                        delay_count_next  = sync_delay_reg;
                        delay_active_next = 1'b1;
                        heat_on_next      = 1'b1;
                    end
                end
                else if (t_ext >= tgt_ext)
                begin
                    heat_on_next      = 1'b0;
                    boost_on_next     = 1'b0;
                    stage_next        = STAGE_CLOSED;
                    delay_count_next  = '0;
                    delay_active_next = 1'b0;
                end
                if (delay_active_next)
                begin
                    if (delay_count_next != '0)
                    begin
                        delay_count_next = delay_count_next - DELAY_W'(1);
                    end
                    else
                    begin
                        delay_active_next = 1'b0;
                        stage_next        = STAGE_OPEN;
                        heat_on_next      = 1'b1;
                        boost_on_next     = 1'b1;
                    end
                end
            end
            default:
            begin
                heat_on_next = 1'b0;
                cool_on_next = 1'b0;
            end
        endcase
    end

    // relay state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_on_reg      <= 1'b0;
            cool_on_reg      <= 1'b0;
            boost_on_reg     <= 1'b0;
            stage_reg        <= STAGE_CLOSED;
            delay_count_reg  <= '0;
            delay_active_reg <= 1'b0;
            fan_out_reg      <= 1'b0;
        end
        else if (s1_advance)
        begin
            heat_on_reg      <= heat_on_next;
            cool_on_reg      <= cool_on_next;
            boost_on_reg     <= boost_on_next;
            stage_reg        <= stage_next;
            delay_count_reg  <= delay_count_next;
            delay_active_reg <= delay_active_next;
            fan_out_reg      <= fan_on_reg;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.heat_relay  = heat_on_reg;
    assign result_out.cool_relay  = cool_on_reg;
    assign result_out.boost_relay = boost_on_reg;
    assign result_out.fan_relay   = fan_out_reg;
    assign result_out.stage       = stage_reg;

    `MHT_ASSERT_SAME(a_relays_exclusive, 1'b1, !(heat_on_reg && cool_on_reg))
    `MHT_ASSERT_SAME(a_open_stage_full, stage_reg == STAGE_OPEN,
                     heat_on_reg && boost_on_reg && !delay_active_reg)
    `MHT_ASSERT_NEXT(a_leave_staged, s1_advance && run_mode_reg != MODE_STAGED,
                     stage_reg == STAGE_CLOSED && !boost_on_reg && !delay_active_reg)
    `MHT_ASSERT_NEXT(a_advance_shows, s1_advance, out_valid_reg)
    `MHT_ASSERT_SAME(a_target_floor, 1'b1, target_reg >= TARGET_FLOOR)

endmodule

/* dv/thermostat_checker.sv */
// Checker: predicts relay results from temperature beats and compares them
`timescale 1ns / 1ps

module thermostat_checker #(
    parameter int unsigned TEMP_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [mht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mht_pkg::CFG_DATA_W-1:0] cfg_wdata,
    mht_in_if                              temp_mon,
    mht_out_if                             result_mon,
    output int                             mismatches,
    output int                             pending
);
    import mht_pkg::*;

    typedef struct packed {
        logic               heat;
        logic               cool;
        logic               boost;
        logic               fan;
        logic [STAGE_W-1:0] stage;
    } relay_set_t;

    logic [MODE_W-1:0]  mode_reg;
    logic               night_reg;
    logic [TGT_W-1:0]   target_reg;
    logic               fan_reg;
    logic [DELAY_W-1:0] sync_reg;

    logic               heat_st;
    logic               cool_st;
    logic               boost_st;
    stage_t             stage_st;
    logic [DELAY_W-1:0] countdown;
    logic               countdown_run;

    relay_set_t         expected_relays[$];
    relay_set_t         oldest;

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic void drop_staging();
        boost_st      = 1'b0;
        stage_st      = STAGE_CLOSED;
        countdown     = '0;
        countdown_run = 1'b0;
    endfunction

    function automatic void write_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_RUN_MODE:    mode_reg = data[MODE_W-1:0];
            CFG_NIGHT_MODE:  night_reg = data[0];
            CFG_TARGET_TEMP: target_reg = (data[TGT_W-1:0] < TARGET_FLOOR) ?
                                          TARGET_FLOOR : data[TGT_W-1:0];
            CFG_FAN_ON:      fan_reg = data[0];
            CFG_SYNC_DELAY:  sync_reg = data[DELAY_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic relay_set_t step_thermostat(input logic [TEMP_BITS-1:0] temp);
        int         t;
        int         tgt;
        int         band;
        relay_set_t r;
        t    = int'(temp);
        tgt  = int'(target_reg);
        band = night_reg ? int'(BAND_NIGHT) : int'(BAND_DAY);
        if (mode_reg != MODE_STAGED)
            drop_staging();
        case (mode_reg)
            MODE_HEAT:
            begin
                if (t <= tgt - band)
                begin
                    heat_st = 1'b1;
                    cool_st = 1'b0;
                end
                else if (t > tgt)
                begin
                    heat_st = 1'b0;
                    cool_st = 1'b0;
                end
            end
            MODE_COOL:
            begin
                if (t >= tgt + band)
                begin
                    cool_st = 1'b1;
                    heat_st = 1'b0;
                end
                else if (t < tgt)
                begin
                    heat_st = 1'b0;
                    cool_st = 1'b0;
                end
            end
            MODE_AUTO:
            begin
                band = night_reg ? int'(BAND_NIGHT_AUTO) : int'(BAND_DAY);
                if (t <= tgt - band)
                begin
                    heat_st = 1'b1;
                    cool_st = 1'b0;
                end
                else if (t >= tgt + band)
                begin
                    cool_st = 1'b1;
                    heat_st = 1'b0;
                end
                else if (t == tgt)
                begin
                    heat_st = 1'b0;
                    cool_st = 1'b0;
                end
            end
            MODE_STAGED:
            begin
                cool_st = 1'b0;
                if (t <= tgt - band)
                begin
                    if (stage_st == STAGE_CLOSED)
                    begin
                        stage_st      = STAGE_WAITING;
                        countdown     = sync_reg;
                        countdown_run = 1'b1;
                        heat_st       = 1'b1;
                    end
                end
                else if (t >= tgt)
                begin
                    heat_st = 1'b0;
                    drop_staging();
                end
                if (countdown_run)
                begin
                    if (countdown != '0)
                        countdown = countdown - DELAY_W'(1);
                    else
                    begin
                        countdown_run = 1'b0;
                        stage_st      = STAGE_OPEN;
                        heat_st       = 1'b1;
                        boost_st      = 1'b1;
                    end
                end
            end
            default:
            begin
                heat_st = 1'b0;
                cool_st = 1'b0;
            end
        endcase
        r.heat  = heat_st;
        r.cool  = cool_st;
        r.boost = boost_st;
        r.fan   = fan_reg;
        r.stage = stage_st;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   = MODE_STOP;
            night_reg  = 1'b0;
            target_reg = TARGET_RESET;
            fan_reg    = 1'b0;
            sync_reg   = DELAY_RESET;
            heat_st    = 1'b0;
            cool_st    = 1'b0;
            drop_staging();
            expected_relays.delete();
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_wen)
                write_setting(cfg_index, cfg_wdata);
            if (result_mon.valid && result_mon.ready)
            begin
                if (expected_relays.size() == 0)
                    flag_mismatch("result beat with nothing expected", 0, 0);
                else
                begin
                    oldest = expected_relays.pop_front();
                    if (result_mon.heat_relay !== oldest.heat)
                        flag_mismatch("heat_relay", result_mon.heat_relay, oldest.heat);
                    if (result_mon.cool_relay !== oldest.cool)
                        flag_mismatch("cool_relay", result_mon.cool_relay, oldest.cool);
                    if (result_mon.boost_relay !== oldest.boost)
                        flag_mismatch("boost_relay", result_mon.boost_relay, oldest.boost);
                    if (result_mon.fan_relay !== oldest.fan)
                        flag_mismatch("fan_relay", result_mon.fan_relay, oldest.fan);
                    if (result_mon.stage !== oldest.stage)
                        flag_mismatch("stage", result_mon.stage, oldest.stage);
                end
            end
            if (temp_mon.valid && temp_mon.ready)
                expected_relays.push_back(step_thermostat(temp_mon.temperature));
            pending <= expected_relays.size();
        end
    end

endmodule

/* dv/testbench.sv */
// Testbench top: clock, reset, register settings, temperature stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import mht_pkg::*;

    localparam int unsigned TEMP_BITS       = 8;
    localparam int          ITEM_TARGET     = 1450;
    localparam int          CYCLE_LIMIT     = 300000;
    localparam int          HOLD_OFF_CYCLES = 64;
    localparam int          LATENCY         = 2;
    localparam int          IDLE_PCT        = 25;
    localparam int          TEMP_MAX        = (1 << TEMP_BITS) - 1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatches;
    int pending;
    int items_sent    = 0;
    int phase_count   = 0;
    int longest_delay = 0;
    int cycles        = 0;
    bit hold_off_req  = 1'b0;

    mht_in_if #(.TEMP_BITS(TEMP_BITS)) temp_ch();
    mht_out_if result_ch();

    multimode_hysteresis_thermostat_unit #(.TEMP_BITS(TEMP_BITS)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .temp_in    (temp_ch),
        .result_out (result_ch)
    );

    thermostat_checker #(.TEMP_BITS(TEMP_BITS)) relay_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .temp_mon   (temp_ch),
        .result_mon (result_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic bit in_steady_stretch();
        return items_sent >= 700 && items_sent < 900;
    endfunction

    function automatic logic [TEMP_BITS-1:0] clamp_temp(input int v);
        if (v < 0)
            return '0;
        if (v > TEMP_MAX)
            return '1;
        return TEMP_BITS'(v);
    endfunction

    // result side: random back-pressure plus one long hold-off
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            result_ch.ready <= in_steady_stretch() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_temp(input logic [TEMP_BITS-1:0] t);
        if (!in_steady_stretch())
            while ($urandom_range(99) < IDLE_PCT)
            begin
                temp_ch.valid <= 1'b0;
                @(posedge clk);
            end
        temp_ch.valid       <= 1'b1;
        temp_ch.temperature <= t;
        @(posedge clk);
        while (!temp_ch.ready)
            @(posedge clk);
        items_sent++;
        if (items_sent == 300)
            hold_off_req = 1'b1;
    endtask

    // drop valid and wait for every outstanding result beat
    task automatic settle();
        temp_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [MODE_W-1:0] mode, input logic night,
                                  input logic [TGT_W-1:0] tgt, input logic fan,
                                  input logic [DELAY_W-1:0] dly, input bit noisy);
        logic [CFG_DATA_W-1:0] pad;
        settle();
        pad = noisy ? CFG_DATA_W'($urandom) : '0;
        write_reg(CFG_RUN_MODE, {pad[CFG_DATA_W-1:MODE_W], mode});
        write_reg(CFG_NIGHT_MODE, {pad[CFG_DATA_W-1:1], night});
        write_reg(CFG_TARGET_TEMP, tgt);
        write_reg(CFG_FAN_ON, {pad[CFG_DATA_W-1:1], fan});
        write_reg(CFG_SYNC_DELAY, dly);
        if (noisy && $urandom_range(3) == 0)
            write_reg(CFG_SYNC_DELAY + CFG_IDX_W'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
        cfg_wen <= 1'b0;
        phase_count++;
        if (int'(dly) > longest_delay)
            longest_delay = int'(dly);
    endtask

    task automatic random_phase();
        logic [MODE_W-1:0]  mode;
        logic [TGT_W-1:0]   tgt;
        logic [DELAY_W-1:0] dly;
        logic               night;
        logic               fan;
        int                 pick;
        int                 tgt_eff;
        int                 band;
        int                 len;
        int                 sent;
        int                 run;
        int                 lo;
        int                 hi;
        pick = $urandom_range(19);
        if (pick == 0)
            mode = MODE_STOP;
        else if (pick == 1)
            mode = MODE_STAGED + MODE_W'($urandom_range(1, 3));
        else if (pick < 6)
            mode = MODE_HEAT;
        else if (pick < 10)
            mode = MODE_COOL;
        else if (pick < 14)
            mode = MODE_AUTO;
        else
            mode = MODE_STAGED;
        pick = $urandom_range(99);
        if (pick < 8)
            tgt = TGT_W'($urandom_range(0, 15));
        else if (pick < 14)
            tgt = '1;
        else if (pick < 20)
            tgt = TARGET_FLOOR;
        else if (pick < 35)
            tgt = TGT_W'($urandom_range(61, 254));
        else
            tgt = TGT_W'($urandom_range(17, 60));
        pick = $urandom_range(99);
        if (pick < 5)
            dly = '1;
        else if (pick < 9)
            dly = DELAY_W'(254);
        else if (pick < 25)
            dly = '0;
        else
            dly = DELAY_W'($urandom_range(1, 6));
        night = 1'($urandom_range(1));
        fan   = 1'($urandom_range(1));
        apply_settings(mode, night, tgt, fan, dly, 1'b1);

        tgt_eff = (tgt < TARGET_FLOOR) ? int'(TARGET_FLOOR) : int'(tgt);
        if (!night)
            band = int'(BAND_DAY);
        else if (mode == MODE_AUTO)
            band = int'(BAND_NIGHT_AUTO);
        else
            band = int'(BAND_NIGHT);
        len = $urandom_range(20, 50);
        if (mode == MODE_STAGED && dly > 20)
            len = int'(dly) + $urandom_range(30, 60);

        // runs of cold, in-band, hot and arbitrary readings around the target
        sent = 0;
        while (sent < len)
        begin
            run = $urandom_range(1, 4);
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    lo = tgt_eff - band - 4;
                    hi = tgt_eff - band;
                    if (mode == MODE_STAGED)
                        run = $urandom_range(1, int'(dly) + 4);
                end
                3, 4:
                begin
                    lo = tgt_eff - band + 1;
                    hi = tgt_eff - 1;
                end
                5:
                begin
                    lo = tgt_eff;
                    hi = tgt_eff;
                end
                6, 7:
                begin
                    lo = tgt_eff;
                    hi = tgt_eff + band + 4;
                end
                8:
                begin
                    lo = 0;
                    hi = TEMP_MAX;
                end
                default:
                begin
                    lo = tgt_eff + 1;
                    hi = tgt_eff + band - 1;
                end
            endcase
            repeat (run)
            begin
                send_temp(clamp_temp(lo + int'($urandom_range(hi - lo))));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_wen             = 1'b0;
        cfg_index           = '0;
        cfg_wdata           = '0;
        temp_ch.valid       = 1'b0;
        temp_ch.temperature = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: stop mode at both temperature extremes
        send_temp('0);
        send_temp('1);
        // heat, day band: on, hold, off, hold
        apply_settings(MODE_HEAT, 1'b0, TGT_W'(24), 1'b1, DELAY_W'(1), 1'b0);
        send_temp(22);
        send_temp(23);
        send_temp(25);
        send_temp(24);
        // cool, night band
        apply_settings(MODE_COOL, 1'b1, TGT_W'(24), 1'b0, DELAY_W'(1), 1'b0);
        send_temp(29);
        send_temp(25);
        send_temp(23);
        // auto, night band, target written below the floor
        apply_settings(MODE_AUTO, 1'b1, '0, 1'b1, DELAY_W'(1), 1'b0);
        send_temp(13);
        send_temp(16);
        send_temp(19);
        send_temp(17);
        // staged heat, zero delay opens on the starting beat, top target
        apply_settings(MODE_STAGED, 1'b0, '1, 1'b0, '0, 1'b0);
        send_temp(250);
        send_temp('0);
        send_temp('1);
        // staged heat: waiting, then open, then off at target
        apply_settings(MODE_STAGED, 1'b1, TGT_W'(30), 1'b1, DELAY_W'(2), 1'b0);
        send_temp(25);
        send_temp(25);
        send_temp(25);
        send_temp(25);
        send_temp(30);
        // unused mode code acts as stop
        apply_settings(MODE_STAGED + MODE_W'(3), 1'b0, TGT_W'(15), 1'b1, DELAY_W'(1), 1'b0);
        send_temp('0);
        send_temp('1);

        while (items_sent < ITEM_TARGET)
            random_phase();

        settle();
        repeat (10) @(posedge clk);
        $display("Drove %0d temperature beats over %0d register settings in %0d cycles",
                 items_sent, phase_count, cycles);
        $display("Covered all modes, unused mode codes, both bands, longest stage delay %0d",
                 longest_delay);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
